/* rtl/core/ternary_weight_block_packer_macros.svh */
// ----------------------------------------------------------------------------
// Ternary weight block packer: assertion macros
// Shared concurrent assertion forms for the packer RTL.
// ----------------------------------------------------------------------------
`ifndef TERNARY_WEIGHT_BLOCK_PACKER_MACROS_SVH
`define TERNARY_WEIGHT_BLOCK_PACKER_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define TWBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-qualified.
`define TWBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/twbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbp_pkg
// Types and constants shared by the ternary weight block packer.
// ----------------------------------------------------------------------------
package twbp_pkg;

  localparam int MAX_BLOCK    = 128;
  localparam int MAX_QUARTERS = MAX_BLOCK / 4;
  localparam int BP_W         = $clog2(MAX_BLOCK);
  localparam int POS_W        = BP_W + 1;
  localparam int QUARTER_W    = $clog2(MAX_QUARTERS + 1);
  localparam int PAD_W        = $clog2(MAX_QUARTERS);
  localparam int REM_W        = $clog2(MAX_QUARTERS + 6);
  localparam int ROW_W        = 16;
  localparam int BSZ_W        = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int SCALE_W      = 32;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [ROW_W-1:0] ROW_LENGTH_RST = 16'd128;
  localparam logic [BSZ_W-1:0] BLOCK_SIZE_RST = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH = 1'b0,
    REG_BLOCK_SIZE = 1'b1
  } cfg_reg_t;

  localparam logic [1:0] CODE_NEG  = 2'd0;
  localparam logic [1:0] CODE_ZERO = 2'd1;
  localparam logic [1:0] CODE_POS  = 2'd2;
  localparam logic [1:0] W_NEG     = 2'b11;
  localparam logic [1:0] W_POS     = 2'b01;
  localparam logic [7:0] PAD_BYTE  = 8'h55;

  // One queued job: an optional code byte, padding bytes, optional scale.
  typedef struct packed {
    logic               code_vld;
    logic [7:0]         code_byte;
    logic [PAD_W-1:0]   pad_cnt;
    logic               scale_vld;
    logic [SCALE_W-1:0] scale;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

endpackage

/* rtl/core/twbp_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbp channel interfaces
// Valid/ready channels for weight input and packed byte output.
// ----------------------------------------------------------------------------
interface twbp_in_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] weight;
  logic [31:0]       scale_bits;

  modport source (output valid, output weight, output scale_bits, input ready);
  modport sink   (input valid, input weight, input scale_bits, output ready);
endinterface

interface twbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* rtl/core/twbp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbp_front
// Accepts weights, tracks row/block position and code grouping, and issues
// one job per weight that causes output.
// ----------------------------------------------------------------------------
module twbp_front
  import twbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  twbp_in_if.sink               in_ch,
  input  qstat_t                qst,
  output logic                  push,
  output cmd_t                  cmd
);

  logic [ROW_W-1:0] row_length_r;
  logic [BSZ_W-1:0] block_size_r;
  logic [ROW_W-1:0] col_r, col_nxt;
  logic [BP_W-1:0]  bp_r, bp_nxt;
  logic [5:0]       pend_r, pend_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             accept;
  logic             blk_end;

  assign in_ch.ready = !qst.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && (cmd.code_vld || blk_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RST;
      block_size_r <= BLOCK_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_ROW_LENGTH: row_length_r <= cfg_wdata[ROW_W-1:0];
        REG_BLOCK_SIZE: block_size_r <= cfg_wdata[BSZ_W-1:0];
      endcase
    end
  end

  always_comb begin
    logic [1:0]           code;
    logic [5:0]           bsq;
    logic [QUARTER_W-1:0] q;
    logic [POS_W-1:0]     bs;
    logic [ROW_W:0]       rl;
    logic [POS_W-1:0]     pos;
    logic [ROW_W:0]       col;
    logic                 row_end;
    logic [5:0]           pend_a;
    logic [1:0]           fill_a;
    logic [POS_W:0]       sum;
    logic [POS_W-2:0]     sent;

    if (in_ch.weight == W_NEG)      code = CODE_NEG;
    else if (in_ch.weight == W_POS) code = CODE_POS;
    else                            code = CODE_ZERO;

    // Drop the low two bits, then clamp to 4..MAX_BLOCK.
    bsq = block_size_r[BSZ_W-1:2];
    if (bsq == 6'd0)                          q = QUARTER_W'(1);
    else if (bsq > 6'(MAX_QUARTERS))          q = QUARTER_W'(MAX_QUARTERS);
    else                                      q = QUARTER_W'(bsq);
    bs  = POS_W'({q, 2'b00});
    rl  = (row_length_r == '0) ? {1'b1, {ROW_W{1'b0}}} : {1'b0, row_length_r};
    pos = {1'b0, bp_r} + POS_W'(1);
    col = {1'b0, col_r} + (ROW_W+1)'(1);
    row_end = (col >= rl);
    blk_end = (pos >= bs) || row_end;
    // Code bytes already sent for this block, rounded up.
    sum  = {1'b0, pos} + (POS_W+1)'(3);
    sent = sum[POS_W:2];

    cmd = '0;
    cmd.scale     = in_ch.scale_bits;
    cmd.scale_vld = blk_end;

    if (fill_r == 2'd3) begin
      cmd.code_vld  = 1'b1;
      cmd.code_byte = {pend_r, code};
      pend_a = '0;
      fill_a = '0;
    end else begin
      pend_a = {pend_r[3:0], code};
      fill_a = fill_r + 2'd1;
    end

    if (blk_end) begin
      // Flush a partial group, padding with zero-weight codes.
      case (fill_a)
        2'd1: begin
          cmd.code_vld  = 1'b1;
          cmd.code_byte = {pend_a[1:0], 6'b010101};
        end
        2'd2: begin
          cmd.code_vld  = 1'b1;
          cmd.code_byte = {pend_a[3:0], 4'b0101};
        end
        2'd3: begin
          cmd.code_vld  = 1'b1;
          cmd.code_byte = {pend_a[5:0], 2'b01};
        end
        default: ;
      endcase
      if (POS_W'(q) > POS_W'(sent)) cmd.pad_cnt = PAD_W'(POS_W'(q) - POS_W'(sent));
      bp_nxt   = '0;
      col_nxt  = row_end ? '0 : col[ROW_W-1:0];
      pend_nxt = '0;
      fill_nxt = '0;
    end else begin
      bp_nxt   = pos[BP_W-1:0];
      col_nxt  = col[ROW_W-1:0];
      pend_nxt = pend_a;
      fill_nxt = fill_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      bp_r   <= '0;
      pend_r <= '0;
      fill_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      bp_r   <= bp_nxt;
      pend_r <= pend_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

/* rtl/core/twbp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbp_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module twbp_queue
  import twbp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   wr_cmd,
  input  logic   pop,
  output cmd_t   rd_cmd,
  output qstat_t qst
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign rd_cmd        = slot_r[rd_ptr_r];
  assign qst.full      = (cnt_r == QCNT_W'(QDEPTH));
  assign qst.not_empty = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

endmodule

/* rtl/core/twbp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbp_back
// Expands queued jobs into the byte stream and drives the output register.
// ----------------------------------------------------------------------------
module twbp_back
  import twbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  qstat_t     qst,
  input  cmd_t       rd_cmd,
  output logic       pop,
  twbp_out_if.source out_ch
);

  logic               code_pend_r;
  logic [7:0]         code_byte_r;
  logic [PAD_W-1:0]   pad_left_r;
  logic [SCALE_W-1:0] scale_r;
  logic [REM_W-1:0]   rem_r;
  logic               out_vld_r;
  logic [7:0]         out_byte_r;
  logic               out_last_r;
  logic               adv;
  logic [7:0]         byte_nxt;

  assign out_ch.valid    = out_vld_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

  assign adv = (rem_r != '0) && (!out_vld_r || out_ch.ready);
  assign pop = qst.not_empty && ((rem_r == '0) || ((rem_r == REM_W'(1)) && adv));

  always_comb begin
    if (code_pend_r)           byte_nxt = code_byte_r;
    else if (pad_left_r != '0) byte_nxt = PAD_BYTE;
    else                       byte_nxt = scale_r[7:0];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_byte_r <= rd_cmd.code_byte;
      pad_left_r  <= rd_cmd.pad_cnt;
      scale_r     <= rd_cmd.scale;
    end else if (adv) begin
      if (!code_pend_r) begin
        if (pad_left_r != '0) pad_left_r <= pad_left_r - PAD_W'(1);
        else                  scale_r    <= {8'd0, scale_r[SCALE_W-1:8]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_pend_r <= 1'b0;
      rem_r       <= '0;
    end else if (pop) begin
      code_pend_r <= rd_cmd.code_vld;
      rem_r       <= REM_W'(rd_cmd.code_vld) + REM_W'(rd_cmd.pad_cnt)
                   + (rd_cmd.scale_vld ? REM_W'(4) : REM_W'(0));
    end else if (adv) begin
      code_pend_r <= 1'b0;
      rem_r       <= rem_r - REM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= byte_nxt;
      out_last_r <= (rem_r == REM_W'(1));
    end
  end

endmodule

/* rtl/core/ternary_weight_block_packer.sv */
`timescale 1ns / 1ps
// Usage: weights enter on in_ch (valid/ready), one transaction per weight, in
// row-major order with the block scale riding on each weight. Packed bytes
// leave on out_ch, one transaction per byte; last marks the final byte that
// a given weight produced. row_length and block_size are written through the
// cfg_ port, by the user only while the block is idle (not enforced).
// Throughput: one weight per cycle while the job queue is not full. A weight
// that completes a group of four codes yields one byte; a weight that ends a
// block yields up to 36 bytes (flush byte, padding, four scale bytes) at one
// byte per cycle when out_ch is ready, set by the single output register.
// A four-entry job queue lets input continue while a block end drains.
// Output path when idle: job queue, back-end job registers, output register.
// Reset (rst_n low, synchronous): registers return to 128/128, row and block
// position clear, queue and output register empty.
// Receiver stall: out_ch holds its byte; once the queue fills, in_ch.ready
// drops until a job leaves.
// ----------------------------------------------------------------------------
// ternary_weight_block_packer
// Packs ternary weights into 2-bit codes with per-block padding and scale.
// ----------------------------------------------------------------------------
`include "ternary_weight_block_packer_macros.svh"

module ternary_weight_block_packer
  import twbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  twbp_in_if.sink               in_ch,
  twbp_out_if.source            out_ch
);

  logic   q_push;
  logic   q_pop;
  cmd_t   wr_cmd;
  cmd_t   rd_cmd;
  qstat_t qst;

  // Front end: classify each weight, update position, issue a job.
  twbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .qst       (qst),
    .push      (q_push),
    .cmd       (wr_cmd)
  );

  // Decouple: hold jobs while the back end drains long block ends.
  twbp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (wr_cmd),
    .pop    (q_pop),
    .rd_cmd (rd_cmd),
    .qst    (qst)
  );

  // Back end: expand each job into bytes, one per cycle while out_ch is ready.
  twbp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .qst    (qst),
    .rd_cmd (rd_cmd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  `TWBP_ASSERT_NOW(a_no_overflow, clk, rst_n, q_push, !qst.full, "job queue overflow")
  `TWBP_ASSERT_NOW(a_no_underflow, clk, rst_n, q_pop, qst.not_empty, "job queue underflow")
  `TWBP_ASSERT_NOW(a_push_on_accept, clk, rst_n, q_push, in_ch.valid && in_ch.ready, "job without input transaction")

endmodule

/* tb/sv/tb_ternary_weight_block_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ternary_weight_block_packer
// Self-checking bench for the ternary weight block packer. A directed table
// drives edge cases first, with a few results typed in by hand. Random
// phases follow under several register settings and idle mixes. Each byte
// not typed is checked against a cycle-free predictor of the packing scheme.
// ----------------------------------------------------------------------------
module tb_ternary_weight_block_packer;
  import twbp_pkg::*;

  // Weight patterns that the package does not name.
  localparam logic [1:0] W_ZERO    = 2'b00;
  localparam logic [1:0] W_NONTERN = 2'b10;  // -2, not a ternary value

  localparam int SETTLE_CYCLES = 10;    // margin for the pipeline to go quiet
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int STALL_LIMIT   = 3000;  // cycles with no transaction at all

  // One expected byte on the output channel.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } pb_t;

  // One row of the directed table: a register write or a weight. Rows with a
  // nonzero n_typed carry their expected bytes, first byte highest.
  typedef struct packed {
    logic        is_cfg;
    cfg_reg_t    reg_sel;
    logic [15:0] cfg_val;
    logic [1:0]  w;
    logic [31:0] scale;
    logic [2:0]  n_typed;
    logic [39:0] typed_bytes;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  twbp_in_if  in_ch();
  twbp_out_if out_ch();

  ternary_weight_block_packer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: registers and packing position, mirrored from the DUT.
  logic [15:0] m_row_len;
  logic [7:0]  m_blk_size;
  int unsigned m_col;
  int unsigned m_bpos;
  logic [5:0]  m_pend;
  int unsigned m_fill;

  pb_t       step_bytes[$];     // bytes caused by the weight just predicted
  pb_t       packed_byte_q[$];  // bytes still owed by the DUT, oldest first
  stim_row_t dir_tbl[$];

  int err_cnt      = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req     = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic void add_byte(input logic [7:0] v);
    pb_t b;
    b.value    = v;
    b.last     = 1'b0;
    step_bytes = {step_bytes, b};
  endfunction

  // Predict the bytes one weight causes and advance the packing state.
  // With keep low the bytes are left in step_bytes only.
  function automatic void pack_weight(input logic [1:0] w, input logic [31:0] scale,
                                      input bit keep);
    logic [1:0]  code;
    logic [7:0]  flush;
    int unsigned bs, rl, pos, col, sent, need;
    bit          blk_end;
    step_bytes.delete();
    case (w)
      W_NEG:   code = CODE_NEG;
      W_POS:   code = CODE_POS;
      default: code = CODE_ZERO;  // zero, and -2 coded like zero
    endcase
    // Drop the low two bits of the block size, then clamp it.
    bs = m_blk_size & 8'hFC;
    if (bs < 4) bs = 4;
    if (bs > MAX_BLOCK) bs = MAX_BLOCK;
    rl = (m_row_len == 16'd0) ? 65536 : m_row_len;
    pos = m_bpos + 1;
    col = m_col + 1;
    blk_end = (pos >= bs) || (col >= rl);

    if (m_fill == 3) begin
      add_byte({m_pend, code});
      m_pend = '0;
      m_fill = 0;
    end else begin
      m_pend = {m_pend[3:0], code};
      m_fill++;
    end

    if (blk_end) begin
      if (m_fill != 0) begin
        flush = ({2'b00, m_pend} << (2 * (4 - m_fill))) | (PAD_BYTE >> (2 * m_fill));
        add_byte(flush);
        m_pend = '0;
        m_fill = 0;
      end
      // A block shrunk mid-row may already have sent more than it needs.
      sent = (pos + 3) / 4;
      need = bs / 4;
      for (int unsigned i = sent; i < need; i++) add_byte(PAD_BYTE);
      for (int i = 0; i < 4; i++) add_byte(scale[8*i +: 8]);
      m_bpos = 0;
      if (col >= rl) begin
        m_col  = 0;
        m_pend = '0;
        m_fill = 0;
      end else begin
        m_col = col & 16'hFFFF;
      end
    end else begin
      m_bpos = pos & 7'h7F;
      m_col  = col & 16'hFFFF;
    end

    if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last = 1'b1;
    if (keep) packed_byte_q = {packed_byte_q, step_bytes};
  endfunction

  function automatic stim_row_t cfg_row(input cfg_reg_t r, input logic [15:0] v);
    stim_row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.reg_sel = r;
    row.cfg_val = v;
    return row;
  endfunction

  function automatic stim_row_t w_row(input logic [1:0] w, input logic [31:0] s,
                                     input logic [2:0] n = 3'd0,
                                     input logic [39:0] b = '0);
    stim_row_t row;
    row = '0;
    row.w           = w;
    row.scale       = s;
    row.n_typed     = n;
    row.typed_bytes = b;
    return row;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input stim_row_t r);
    dir_tbl = {dir_tbl, r};
  endfunction

  // Offer one weight after a random gap; return at the accepting edge.
  task automatic drive_weight(input logic [1:0] w, input logic [31:0] s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.weight     <= w;
    in_ch.scale_bits <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every owed byte, then let the pipeline go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (packed_byte_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register in a single cycle and mirror it in the predictor.
  task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    @(posedge clk);
    if (r == REG_ROW_LENGTH) m_row_len = v;
    else                     m_blk_size = v[7:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram both registers while idle, then stream random weights.
  task automatic run_phase(input logic [15:0] rl, input logic [7:0] bs, input int n_items,
                           input bit with_hold);
    logic [1:0]  w;
    logic [31:0] s;
    int          pick;
    settle();
    write_reg(REG_ROW_LENGTH, rl);
    write_reg(REG_BLOCK_SIZE, {8'h00, bs});
    if (with_hold) hold_req = 1;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if      (pick < 10) w = W_NONTERN;
      else if (pick < 40) w = W_NEG;
      else if (pick < 70) w = W_ZERO;
      else                w = W_POS;
      case ($urandom_range(9))
        0:       s = 32'h0000_0000;
        1:       s = 32'hFFFF_FFFF;
        default: s = $urandom;
      endcase
      drive_weight(w, s);
      pack_weight(w, s, 1'b1);
    end
  endtask

  // Receiver: random ready, with one long hold-off on request so the job
  // queue fills and the input channel must stall.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        out_ch.ready <= 1'b0;
        hold_cnt--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Check each output transaction against the oldest owed byte.
  always @(posedge clk) begin
    pb_t exp_b;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (packed_byte_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  out_ch.out_byte, out_ch.last));
      end else begin
        exp_b = packed_byte_q.pop_front();
        if (out_ch.out_byte !== exp_b.value)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_ch.out_byte, exp_b.value));
        if (out_ch.last !== exp_b.last)
          report_mismatch($sformatf("last %0b on byte %02h, expected %0b",
                                    out_ch.last, out_ch.out_byte, exp_b.last));
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    pb_t       tb;
    // Hold every input at a known value from time zero.
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_ROW_LENGTH;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.weight     <= W_ZERO;
    in_ch.scale_bits <= '0;

    m_row_len  = ROW_LENGTH_RST;
    m_blk_size = BLOCK_SIZE_RST;
    m_col      = 0;
    m_bpos     = 0;
    m_pend     = '0;
    m_fill     = 0;

    // One-weight rows: every weight is a whole row and a whole 4-wide block,
    // so each yields the flush byte and the scale, nothing else.
    add_row(cfg_row(REG_ROW_LENGTH, 16'd1));
    add_row(cfg_row(REG_BLOCK_SIZE, 16'd4));
    add_row(w_row(W_POS,     32'h1234_5678, 3'd5, 40'h95_78_56_34_12));
    add_row(w_row(W_NEG,     32'hFFFF_FFFF, 3'd5, 40'h15_FF_FF_FF_FF));
    add_row(w_row(W_ZERO,    32'h0000_0000, 3'd5, 40'h55_00_00_00_00));
    add_row(w_row(W_NONTERN, 32'h8000_0001, 3'd5, 40'h55_01_00_00_80));
    // Row length zero means 65536; block size zero clamps up to four.
    add_row(cfg_row(REG_ROW_LENGTH, 16'd0));
    add_row(cfg_row(REG_BLOCK_SIZE, 16'd0));
    add_row(w_row(W_POS,     32'h0000_00FF));
    add_row(w_row(W_NEG,     32'hFF00_0000));
    add_row(w_row(W_ZERO,    32'h0F0F_0F0F));
    add_row(w_row(W_POS,     32'hA5A5_A5A5));
    // Oversized block clamps to the maximum; row length 65535.
    add_row(cfg_row(REG_BLOCK_SIZE, 16'd255));
    add_row(cfg_row(REG_ROW_LENGTH, 16'hFFFF));
    add_row(w_row(W_NEG,     32'h0000_0001));
    add_row(w_row(W_NEG,     32'h0000_0002));
    add_row(w_row(W_POS,     32'h0000_0003));
    add_row(w_row(W_NONTERN, 32'h0000_0004));
    add_row(w_row(W_POS,     32'h0000_0005));
    add_row(w_row(W_ZERO,    32'h0000_0006));
    add_row(w_row(W_NEG,     32'h0000_0007));
    add_row(w_row(W_POS,     32'h0000_0008));
    add_row(w_row(W_POS,     32'h0000_0009));
    // Shrink the block mid-row below what was already sent: no padding.
    add_row(cfg_row(REG_BLOCK_SIZE, 16'd8));
    add_row(w_row(W_ZERO,    32'hDEAD_BEEF));
    // Shrink the row below the current column, then a short row that pads
    // a full maximum block: the first weight hits the most bytes per weight.
    add_row(cfg_row(REG_ROW_LENGTH, 16'd5));
    add_row(cfg_row(REG_BLOCK_SIZE, 16'd128));
    add_row(w_row(W_POS,     32'h7F80_0000));
    add_row(w_row(W_NEG,     32'h3F80_0000));
    add_row(w_row(W_ZERO,    32'hBF80_0000));
    add_row(w_row(W_POS,     32'h0080_0000));
    add_row(w_row(W_NONTERN, 32'h4000_0000));
    add_row(w_row(W_NEG,     32'hC000_0000));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slow receiver, mostly busy sender.
    snd_idle_pct = 27;
    rcv_idle_pct = 84;

    // Walk the directed table; typed rows still advance the predictor.
    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.reg_sel, row.cfg_val);
      end else begin
        drive_weight(row.w, row.scale);
        pack_weight(row.w, row.scale, row.n_typed == 3'd0);
        for (int k = 0; k < row.n_typed; k++) begin
          tb.value = row.typed_bytes[8*(row.n_typed-1-k) +: 8];
          tb.last  = (k == row.n_typed - 1);
          packed_byte_q = {packed_byte_q, tb};
        end
      end
    end

    run_phase(16'd7,    8'd4,   60, 1'b0);
    run_phase(16'd128,  8'd128, 50, 1'b0);
    run_phase(16'd1,    8'd128, 12, 1'b0);

    // Slow sender, mostly ready receiver.
    snd_idle_pct = 84;
    rcv_idle_pct = 27;
    run_phase(16'd0,    8'd255, 60, 1'b0);
    run_phase(16'd20,   8'd12,  60, 1'b0);
    run_phase(16'hFFFF, 8'd3,   50, 1'b0);

    // Both sides at full rate; the first phase holds the receiver off.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(16'd13,   8'd8,   70, 1'b1);
    run_phase(16'd2,    8'd6,   40, 1'b0);
    run_phase(16'd100,  8'd64,  36, 1'b0);

    settle();
    if (err_cnt == 0 && packed_byte_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
